[src/gkd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkd_pkg
// shared types and codes of the multi-key debouncer
// ----------------------------------------------------------------------------
package gkd_pkg;

    localparam int CFG_INDEX_W  = 2;
    localparam int KEY_INDEX_W  = 5;
    localparam int KEYS_USED_W  = 6;
    localparam int TICKS_W      = 16;
    localparam int MASK_W       = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYS_USED      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LEVELS  = 2'd2;

    // reset values of the configuration registers
    localparam logic [KEYS_USED_W-1:0] KEYS_USED_RESET      = 6'd32;
    localparam logic [TICKS_W-1:0]     DEBOUNCE_TICKS_RESET = 16'd6;
    localparam logic [MASK_W-1:0]      ACTIVE_LEVELS_RESET  = 32'hFFFF_FFFF;

    // input item opcodes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result item kinds
    localparam logic EVT_KEY  = 1'b0;
    localparam logic EVT_SYNC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SYNC
    } state_t;

endpackage
`default_nettype wire

[src/gpio_key_debouncer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// an edge item or a tick item is taken only while idle and gives no result,
// except the tick that expires the countdown; that one starts a scan.
// a scan steps through min(MAX_KEYS, 32) key slots one per cycle while the output
// is not stalled, on a single bit comparator, then emits the sync marker.
// no item is taken during a scan.
// reset clears stored levels, pending set, countdown and config to defaults.
// ----------------------------------------------------------------------------
// gpio_key_debouncer_core
// multi-key debouncer: pending set, debounce countdown and serial key scan
// ----------------------------------------------------------------------------
module gpio_key_debouncer_core #(
    parameter int MAX_KEYS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gkd_pkg::MASK_W-1:0]     cfg_data,

    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic                           opcode,
    input  wire logic [gkd_pkg::MASK_W-1:0]     edge_mask,
    input  wire logic [gkd_pkg::MASK_W-1:0]     pin_levels,

    output logic                                evt_valid,
    input  wire logic                           evt_stall,
    output logic                                event_kind,
    output logic [gkd_pkg::KEY_INDEX_W-1:0]     key_index,
    output logic                                pressed,
    output logic                                last
);

    localparam int NUM_SLOTS = (MAX_KEYS < 32) ? MAX_KEYS : 32;

    gkd_pkg::state_t state_reg, state_next;

    logic [gkd_pkg::KEYS_USED_W-1:0] keys_used_reg;
    logic [gkd_pkg::TICKS_W-1:0]     debounce_ticks_reg;
    logic [gkd_pkg::MASK_W-1:0]      active_levels_reg;

    logic [gkd_pkg::TICKS_W-1:0]     countdown_reg, countdown_next;
    logic [NUM_SLOTS-1:0]            pending_reg, pending_next;
    logic [NUM_SLOTS-1:0]            levels_reg, levels_next;
    logic [NUM_SLOTS-1:0]            pin_snap_reg, pin_snap_next;
    logic [NUM_SLOTS-1:0]            act_snap_reg, act_snap_next;
    logic [gkd_pkg::KEY_INDEX_W-1:0] idx_reg, idx_next;

    logic                            evt_valid_reg, evt_valid_next;
    logic                            event_kind_reg, event_kind_next;
    logic [gkd_pkg::KEY_INDEX_W-1:0] key_index_reg, key_index_next;
    logic                            pressed_reg, pressed_next;
    logic                            last_reg, last_next;

    logic                            out_free;
    logic [NUM_SLOTS-1:0]            slot_mask;
    logic                            new_level;

    // slots below the number of keys in use take part in the scan
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_mask[i] = (gkd_pkg::KEYS_USED_W'(i) < keys_used_reg);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_used_reg      <= gkd_pkg::KEYS_USED_RESET;
            debounce_ticks_reg <= gkd_pkg::DEBOUNCE_TICKS_RESET;
            active_levels_reg  <= gkd_pkg::ACTIVE_LEVELS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gkd_pkg::CFG_KEYS_USED:
                    keys_used_reg <= cfg_data[gkd_pkg::KEYS_USED_W-1:0];
                gkd_pkg::CFG_DEBOUNCE_TICKS:
                    debounce_ticks_reg <= cfg_data[gkd_pkg::TICKS_W-1:0];
                gkd_pkg::CFG_ACTIVE_LEVELS:
                    active_levels_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gkd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
            pending_reg   <= '0;
            levels_reg    <= '0;
            idx_reg       <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            pending_reg   <= pending_next;
            levels_reg    <= levels_next;
            idx_reg       <= idx_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pin_snap_reg   <= pin_snap_next;
        act_snap_reg   <= act_snap_next;
        event_kind_reg <= event_kind_next;
        key_index_reg  <= key_index_next;
        pressed_reg    <= pressed_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        countdown_next  = countdown_reg;
        pending_next    = pending_reg;
        levels_next     = levels_reg;
        pin_snap_next   = pin_snap_reg;
        act_snap_next   = act_snap_reg;
        idx_next        = idx_reg;
        evt_valid_next  = evt_valid_reg && evt_stall;
        event_kind_next = event_kind_reg;
        key_index_next  = key_index_reg;
        pressed_next    = pressed_reg;
        last_next       = last_reg;
        out_free        = !evt_valid_reg || !evt_stall;
        new_level       = pending_reg[0] ? pin_snap_reg[0] : levels_reg[0];
        item_stall      = (state_reg != gkd_pkg::ST_IDLE);

        unique case (state_reg)
            gkd_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (opcode == gkd_pkg::OP_EDGE)
                    begin
                        pending_next   = pending_reg | edge_mask[NUM_SLOTS-1:0];
                        countdown_next = (debounce_ticks_reg == '0) ?
                                         gkd_pkg::TICKS_W'(1) : debounce_ticks_reg;
                    end
                    else if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - gkd_pkg::TICKS_W'(1);
                        if (countdown_reg == gkd_pkg::TICKS_W'(1))
                        begin
                            pin_snap_next = pin_levels[NUM_SLOTS-1:0];
                            act_snap_next = active_levels_reg[NUM_SLOTS-1:0];
                            pending_next  = pending_reg & slot_mask;
                            idx_next      = '0;
                            state_next    = gkd_pkg::ST_SCAN;
                        end
                    end
                end
            end

            gkd_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    if (pending_reg[0] && (pin_snap_reg[0] != levels_reg[0]))
                    begin
                        evt_valid_next  = 1'b1;
                        event_kind_next = gkd_pkg::EVT_KEY;
                        key_index_next  = idx_reg;
                        pressed_next    = (pin_snap_reg[0] == act_snap_reg[0]);
                        last_next       = 1'b0;
                    end
                    // slot 0 of each vector is the key under test; levels rotate
                    levels_next                = levels_reg >> 1;
                    levels_next[NUM_SLOTS-1]   = new_level;
                    pending_next               = pending_reg >> 1;
                    pin_snap_next              = pin_snap_reg >> 1;
                    act_snap_next              = act_snap_reg >> 1;
                    idx_next                   = idx_reg + gkd_pkg::KEY_INDEX_W'(1);
                    if (idx_reg == gkd_pkg::KEY_INDEX_W'(NUM_SLOTS - 1))
                    begin
                        state_next = gkd_pkg::ST_SYNC;
                    end
                end
            end

            gkd_pkg::ST_SYNC:
            begin
                if (out_free)
                begin
                    evt_valid_next  = 1'b1;
                    event_kind_next = gkd_pkg::EVT_SYNC;
                    key_index_next  = '0;
                    pressed_next    = 1'b0;
                    last_next       = 1'b1;
                    pending_next    = '0;
                    state_next      = gkd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gkd_pkg::ST_IDLE;
            end
        endcase
    end

    assign evt_valid  = evt_valid_reg;
    assign event_kind = event_kind_reg;
    assign key_index  = key_index_reg;
    assign pressed    = pressed_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

[src/gkd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkd_checker
// port-level checks of the multi-key debouncer
// ----------------------------------------------------------------------------
module gkd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            item_valid,
    input wire logic                            item_stall,
    input wire logic                            opcode,
    input wire logic                            evt_valid,
    input wire logic                            evt_stall,
    input wire logic                            event_kind,
    input wire logic [gkd_pkg::KEY_INDEX_W-1:0] key_index,
    input wire logic                            pressed,
    input wire logic                            last
);

    // a held result keeps its payload
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(event_kind)
            && $stable(key_index) && $stable(pressed) && $stable(last))
        else $error("stalled result changed");

    // the sync marker carries last and no key data
    a_sync_form: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (event_kind == gkd_pkg::EVT_SYNC) |->
            last && (key_index == '0) && !pressed)
        else $error("malformed sync marker");

    a_key_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (event_kind == gkd_pkg::EVT_KEY) |-> !last)
        else $error("key event flagged last");

    // an edge item never starts a scan
    a_edge_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (opcode == gkd_pkg::OP_EDGE) |=> !item_stall)
        else $error("edge item started a scan");

endmodule

bind gpio_key_debouncer_core gkd_checker u_gkd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .event_kind (event_kind),
    .key_index  (key_index),
    .pressed    (pressed),
    .last       (last)
);
`default_nettype wire

[tb/gkd_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkd_event_checker
// watches the register, item and event channels of the key debouncer, keeps
// its own copy of levels, pending set and countdown, and compares every
// accepted event with the oldest predicted one
// ----------------------------------------------------------------------------
module gkd_event_checker #(
    parameter int MAX_KEYS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [gkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gkd_pkg::MASK_W-1:0]     cfg_data,

    input  wire logic                           item_valid,
    input  wire logic                           item_stall,
    input  wire logic                           opcode,
    input  wire logic [gkd_pkg::MASK_W-1:0]     edge_mask,
    input  wire logic [gkd_pkg::MASK_W-1:0]     pin_levels,

    input  wire logic                           evt_valid,
    input  wire logic                           evt_stall,
    input  wire logic                           event_kind,
    input  wire logic [gkd_pkg::KEY_INDEX_W-1:0] key_index,
    input  wire logic                           pressed,
    input  wire logic                           last,

    output int                                  mismatches,
    output int                                  pending_results,
    output int                                  key_events,
    output int                                  scans
);

    typedef struct packed {
        logic                            kind;
        logic [gkd_pkg::KEY_INDEX_W-1:0] index;
        logic                            pressed;
        logic                            last;
    } key_event_t;

    // predictor copy of the registers and state
    logic [gkd_pkg::KEYS_USED_W-1:0] keys_used_r;
    logic [gkd_pkg::TICKS_W-1:0]     ticks_r;
    logic [gkd_pkg::MASK_W-1:0]      active_r;
    logic [gkd_pkg::MASK_W-1:0]      stable_levels;
    logic [gkd_pkg::MASK_W-1:0]      pending_keys;
    logic [gkd_pkg::TICKS_W-1:0]     countdown;

    key_event_t expected_events[$];

    int mismatch_cnt  = 0;
    int key_event_cnt = 0;
    int scan_cnt      = 0;
    int queued_cnt    = 0;

    assign mismatches      = mismatch_cnt;
    assign key_events      = key_event_cnt;
    assign scans           = scan_cnt;
    assign pending_results = queued_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // countdown expired: walk the pending keys in use, lowest first
    task automatic scan_pending(input logic [gkd_pkg::MASK_W-1:0] levels);
        int         limit;
        key_event_t ev;
        limit = int'(keys_used_r);
        if (limit > MAX_KEYS)
            limit = MAX_KEYS;
        if (limit > gkd_pkg::MASK_W)
            limit = gkd_pkg::MASK_W;
        for (int i = 0; i < limit; i++)
        begin
            if (pending_keys[i] && (levels[i] != stable_levels[i]))
            begin
                stable_levels[i] = levels[i];
                ev.kind    = gkd_pkg::EVT_KEY;
                ev.index   = gkd_pkg::KEY_INDEX_W'(i);
                ev.pressed = (levels[i] == active_r[i]);
                ev.last    = 1'b0;
                expected_events.push_back(ev);
            end
        end
        ev.kind    = gkd_pkg::EVT_SYNC;
        ev.index   = '0;
        ev.pressed = 1'b0;
        ev.last    = 1'b1;
        expected_events.push_back(ev);
        pending_keys = '0;
    endtask

    task automatic debounce_step(input logic op, input logic [gkd_pkg::MASK_W-1:0] mask,
                                 input logic [gkd_pkg::MASK_W-1:0] levels);
        if (op == gkd_pkg::OP_EDGE)
        begin
            pending_keys = pending_keys | mask;
            countdown    = (ticks_r == '0) ? gkd_pkg::TICKS_W'(1) : ticks_r;
        end
        else if (countdown != '0)
        begin
            countdown = countdown - gkd_pkg::TICKS_W'(1);
            if (countdown == '0)
                scan_pending(levels);
        end
    endtask

    task automatic check_event();
        key_event_t exp;
        if (expected_events.size() == 0)
        begin
            report_mismatch($sformatf("unexpected item kind=%0d key=%0d pressed=%0d last=%0d",
                                      event_kind, key_index, pressed, last));
            return;
        end
        exp = expected_events.pop_front();
        if (event_kind !== exp.kind)
            report_mismatch($sformatf("event_kind %0d, expected %0d (key %0d)",
                                      event_kind, exp.kind, exp.index));
        if (key_index !== exp.index)
            report_mismatch($sformatf("key_index %0d, expected %0d", key_index, exp.index));
        if (pressed !== exp.pressed)
            report_mismatch($sformatf("pressed %0d, expected %0d (key %0d)",
                                      pressed, exp.pressed, exp.index));
        if (last !== exp.last)
            report_mismatch($sformatf("last %0d, expected %0d (key %0d)",
                                      last, exp.last, exp.index));
        if (exp.kind == gkd_pkg::EVT_SYNC)
            scan_cnt++;
        else
            key_event_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            keys_used_r   = gkd_pkg::KEYS_USED_RESET;
            ticks_r       = gkd_pkg::DEBOUNCE_TICKS_RESET;
            active_r      = gkd_pkg::ACTIVE_LEVELS_RESET;
            stable_levels = '0;
            pending_keys  = '0;
            countdown     = '0;
            expected_events.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gkd_pkg::CFG_KEYS_USED:
                        keys_used_r = cfg_data[gkd_pkg::KEYS_USED_W-1:0];
                    gkd_pkg::CFG_DEBOUNCE_TICKS:
                        ticks_r = cfg_data[gkd_pkg::TICKS_W-1:0];
                    gkd_pkg::CFG_ACTIVE_LEVELS:
                        active_r = cfg_data;
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                debounce_step(opcode, edge_mask, pin_levels);
            if (evt_valid && !evt_stall)
                check_event();
        end
        queued_cnt = expected_events.size();
    end

endmodule

[tb/gpio_key_debouncer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_key_debouncer_core_tb
// drives edge and tick items and register writes into the key debouncer with
// random gaps and output stalls; the event checker predicts and compares
// ----------------------------------------------------------------------------
module gpio_key_debouncer_core_tb;

    localparam int                              MAX_KEYS      = 32;
    localparam int                              RANDOM_ITEMS  = 200;
    localparam int                              SETTLE_CYCLES = MAX_KEYS + 8;
    localparam logic [gkd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [gkd_pkg::MASK_W-1:0]      ALL_ONES      = 32'hFFFF_FFFF;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gkd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gkd_pkg::MASK_W-1:0]      cfg_data;
    logic                            item_valid;
    logic                            item_stall;
    logic                            opcode;
    logic [gkd_pkg::MASK_W-1:0]      edge_mask;
    logic [gkd_pkg::MASK_W-1:0]      pin_levels;
    logic                            evt_valid;
    logic                            evt_stall;
    logic                            event_kind;
    logic [gkd_pkg::KEY_INDEX_W-1:0] key_index;
    logic                            pressed;
    logic                            last;

    int mismatches;
    int pending_results;
    int key_events;
    int scans;

    int items_sent   = 0;
    int settings_cnt = 0;
    int cur_ticks    = 6;
    bit calm         = 1'b0;

    gpio_key_debouncer_core #(
        .MAX_KEYS   (MAX_KEYS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .edge_mask  (edge_mask),
        .pin_levels (pin_levels),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .event_kind (event_kind),
        .key_index  (key_index),
        .pressed    (pressed),
        .last       (last)
    );

    gkd_event_checker #(
        .MAX_KEYS        (MAX_KEYS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .opcode          (opcode),
        .edge_mask       (edge_mask),
        .pin_levels      (pin_levels),
        .evt_valid       (evt_valid),
        .evt_stall       (evt_stall),
        .event_kind      (event_kind),
        .key_index       (key_index),
        .pressed         (pressed),
        .last            (last),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .key_events      (key_events),
        .scans           (scans)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout with %0d results outstanding", pending_results);
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [gkd_pkg::MASK_W-1:0] rand_word();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return gkd_pkg::MASK_W'(1) << $urandom_range(0, gkd_pkg::MASK_W - 1);
            3:       return ~(gkd_pkg::MASK_W'(1) << $urandom_range(0, gkd_pkg::MASK_W - 1));
            4:       return $urandom() & $urandom();
            default: return $urandom();
        endcase
    endfunction

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [gkd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gkd_pkg::MASK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // upper data bits beyond the register width are random and must be dropped
    task automatic set_config(input logic [gkd_pkg::KEYS_USED_W-1:0] kc,
                              input logic [gkd_pkg::TICKS_W-1:0] dt,
                              input logic [gkd_pkg::MASK_W-1:0] al);
        logic [gkd_pkg::MASK_W-1:0] junk;
        junk = $urandom();
        write_reg(gkd_pkg::CFG_KEYS_USED,
                  {junk[gkd_pkg::MASK_W-1:gkd_pkg::KEYS_USED_W], kc});
        write_reg(gkd_pkg::CFG_DEBOUNCE_TICKS,
                  {junk[gkd_pkg::MASK_W-1:gkd_pkg::TICKS_W], dt});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, $urandom());
        write_reg(gkd_pkg::CFG_ACTIVE_LEVELS, al);
        cfg_valid <= 1'b0;
        cur_ticks = (dt == '0) ? 1 : int'(dt);
        settings_cnt++;
    endtask

    task automatic send_item(input logic op, input logic [gkd_pkg::MASK_W-1:0] mask,
                             input logic [gkd_pkg::MASK_W-1:0] levels);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        edge_mask  <= mask;
        pin_levels <= levels;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(gkd_pkg::OP_TICK, $urandom(), rand_word());
    endtask

    // hold the sender until every predicted event is out, then let the scan settle
    task automatic drain_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one or more bouncing edges, each restarting the countdown, then quiet until expiry
    task automatic press_sequence(input int edges);
        for (int e = 0; e < edges; e++)
        begin
            send_item(gkd_pkg::OP_EDGE, rand_word(), $urandom());
            if (e < edges - 1)
                send_ticks($urandom_range(0, cur_ticks - 1));
        end
        send_ticks(cur_ticks);
    endtask

    task automatic random_config();
        logic [gkd_pkg::KEYS_USED_W-1:0] kc;
        logic [gkd_pkg::TICKS_W-1:0]     dt;
        logic [gkd_pkg::MASK_W-1:0]      al;
        case ($urandom_range(0, 7))
            0:       kc = 6'd0;
            1:       kc = 6'd1;
            2:       kc = 6'd33 + gkd_pkg::KEYS_USED_W'($urandom_range(0, 30));
            3, 4:    kc = gkd_pkg::KEYS_USED_W'($urandom_range(2, 31));
            default: kc = 6'd32;
        endcase
        case ($urandom_range(0, 7))
            0:       dt = '0;
            1:       dt = 16'd1;
            2:       dt = gkd_pkg::TICKS_W'($urandom_range(10, 20));
            default: dt = gkd_pkg::TICKS_W'($urandom_range(2, 6));
        endcase
        case ($urandom_range(0, 3))
            0:       al = '0;
            1:       al = ALL_ONES;
            default: al = $urandom();
        endcase
        set_config(kc, dt, al);
    endtask

    initial
    begin
        int random_start;
        int bursts;
        int r;

        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        opcode     <= gkd_pkg::OP_EDGE;
        edge_mask  <= '0;
        pin_levels <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle tick, then every key goes from released to pressed
        send_item(gkd_pkg::OP_TICK, $urandom(), ALL_ONES);
        send_item(gkd_pkg::OP_EDGE, ALL_ONES, $urandom());
        send_ticks(0);
        repeat (6) send_item(gkd_pkg::OP_TICK, $urandom(), ALL_ONES);
        drain_results();

        // restart while counting, an expiry that reports keys 0, 1 and 31, then one that changes nothing
        set_config(6'd32, 16'd2, 32'h0000_FFFF);
        send_item(gkd_pkg::OP_EDGE, 32'h8000_0001, '0);
        send_item(gkd_pkg::OP_TICK, '0, ALL_ONES);
        send_item(gkd_pkg::OP_EDGE, 32'h0000_0002, ALL_ONES);
        repeat (2) send_item(gkd_pkg::OP_TICK, ALL_ONES, '0);
        send_item(gkd_pkg::OP_EDGE, '0, '0);
        repeat (2) send_item(gkd_pkg::OP_TICK, '0, $urandom());
        drain_results();

        // no keys in use with zero debounce: only the sync marker, pending cleared
        set_config(6'd0, 16'd0, '0);
        send_item(gkd_pkg::OP_EDGE, ALL_ONES, '0);
        send_item(gkd_pkg::OP_TICK, '0, $urandom());
        drain_results();

        // key count above the limit scans all slots
        set_config(6'd63, 16'd1, ALL_ONES);
        send_item(gkd_pkg::OP_EDGE, ALL_ONES, '0);
        send_item(gkd_pkg::OP_TICK, '0, 32'h5555_5555);
        drain_results();

        // one key only, edges beyond it are dropped
        set_config(6'd1, 16'd1, ALL_ONES);
        send_item(gkd_pkg::OP_EDGE, ALL_ONES, '0);
        send_item(gkd_pkg::OP_TICK, '0, 32'hAAAA_AAAA);
        drain_results();

        // longest debounce, cut short by a restart under a short one
        set_config(6'd33, 16'hFFFF, $urandom());
        send_item(gkd_pkg::OP_EDGE, ALL_ONES, '0);
        repeat (3) send_item(gkd_pkg::OP_TICK, $urandom(), $urandom());
        drain_results();
        set_config(6'd32, 16'd1, $urandom());
        send_item(gkd_pkg::OP_EDGE, 32'h0F0F_F0F0, '0);
        send_item(gkd_pkg::OP_TICK, $urandom(), $urandom());
        drain_results();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            random_config();
            calm   = ($urandom_range(0, 3) == 0);
            bursts = $urandom_range(3, 6);
            repeat (bursts)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    press_sequence($urandom_range(1, 3));
                else if (r == 7)
                    send_ticks($urandom_range(1, 3));
                else if (r == 8)
                begin
                    // bounce that never settles before the next burst
                    send_item(gkd_pkg::OP_EDGE, rand_word(), $urandom());
                    send_ticks($urandom_range(0, cur_ticks - 1));
                end
                else
                    drain_results();
            end
            press_sequence(1);
            drain_results();
        end
        calm = 1'b0;

        drain_results();
        $display("covered %0d items under %0d register settings", items_sent, settings_cnt);
        $display("checked %0d key events in %0d scans", key_events, scans);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // output stalls: bursts of random length, with stretches of none
    initial
    begin
        int stall_len;
        int free_len;
        evt_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                stall_len = 0;
                free_len  = $urandom_range(20, 80);
            end
            else
            begin
                stall_len = pick_gap();
                free_len  = $urandom_range(1, 6);
            end
            if (stall_len > 0)
            begin
                evt_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            evt_stall <= 1'b0;
            repeat (free_len) @(posedge clk);
        end
    end

endmodule

[sim.f]
src/gkd_pkg.sv
src/gpio_key_debouncer_core.sv
src/gkd_checker.sv
tb/gkd_event_checker.sv
tb/gpio_key_debouncer_core_tb.sv
